[rtl/sird_pkg.sv]
// Package for the signed integer to radix digits unit.
// Holds widths, character codes, register indexes, the sequencer states and
// the reciprocal table of the divider. Depends on nothing.
package sird_pkg;

	localparam int unsigned MAX_RADIX = 16;
	localparam int unsigned SYM_COUNT = 16;
	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned CHAR_W    = 8;
	localparam int unsigned RADIX_W   = 5;
	localparam int unsigned DIGIT_W   = 4;
	localparam int unsigned COUNT_W   = 6;
	localparam int unsigned DEPTH     = 32;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 64;

	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
	localparam logic [CHAR_W-1:0] CHAR_DEL   = 8'd127;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SYMBOLS_LOW  = 2'd0,
		CFG_SYMBOLS_HIGH = 2'd1,
		CFG_RADIX_LEN    = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIX,
		ST_SIGN,
		ST_EMIT
	} state_t;

	// floor(2^32 / r): the quotient estimate is exact or one short.
	function automatic logic [VALUE_W-1:0] recip(input logic [RADIX_W-1:0] r);
		logic [VALUE_W-1:0] m;
		unique case (r)
			5'd2:    m = 32'h8000_0000;
			5'd3:    m = 32'h5555_5555;
			5'd4:    m = 32'h4000_0000;
			5'd5:    m = 32'h3333_3333;
			5'd6:    m = 32'h2AAA_AAAA;
			5'd7:    m = 32'h2492_4924;
			5'd8:    m = 32'h2000_0000;
			5'd9:    m = 32'h1C71_C71C;
			5'd10:   m = 32'h1999_9999;
			5'd11:   m = 32'h1745_D174;
			5'd12:   m = 32'h1555_5555;
			5'd13:   m = 32'h13B1_3B13;
			5'd14:   m = 32'h1249_2492;
			5'd15:   m = 32'h1111_1111;
			5'd16:   m = 32'h1000_0000;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

[rtl/sird_if.sv]
// Valid/ready channel interfaces of the signed integer to radix digits unit:
// operand, result and configuration write channels.
// Depends on sird_pkg for the payload widths.
interface sird_in_if import sird_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface sird_out_if import sird_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface

interface sird_cfg_if import sird_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/signed_int_to_radix_digits_unit.sv]
// Signed integer to radix digits unit: top level.
// Converts a signed 32-bit operand into alphabet characters, most significant first.
// Depends on sird_pkg and the channel interfaces in sird_if.sv.
//
// Usage notes.
// The configuration channel is always ready. Index 0 writes symbols 0 to 7, index 1
// writes symbols 8 to 15 (symbol 0 or 8 in the low byte), index 2 writes the radix
// length. The user must make writes only while the unit is idle; the unit does not
// enforce this. The alphabet is checked on every operand; an invalid alphabet gives
// no characters at all. The operand channel takes one beat whenever the unit is idle.
// Each digit then goes through the shared divider: first the 32 by 32 reciprocal
// multiply, then the remainder and quotient correction. All digits of a value are
// divided out before its first character is loaded into the output register; the
// characters then leave one per cycle while the receiver is ready, an optional minus
// sign first.
// The result channel is driven from a register; a stalled receiver holds the
// current character and pauses the read-out. The unit is ready for the next operand
// as soon as the final character, marked by last, sits in the output register.
// Reset clears the configuration registers, the sequencer and the output valid.
module signed_int_to_radix_digits_unit import sird_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sird_cfg_if.sink    cfg,
	sird_in_if.sink     operand,
	sird_out_if.source  result
);

	// Configuration registers.
	logic [CFG_DATA_W-1:0] symbols_low_q;
	logic [CFG_DATA_W-1:0] symbols_high_q;
	logic [RADIX_W-1:0]    radix_len_q;

	// Sequencer and datapath registers.
	state_t               state_q, state_d;
	logic [COUNT_W-1:0]   nd_q;
	logic                 neg_q;
	logic [VALUE_W-1:0]   mag_q;
	logic [2*VALUE_W-1:0] prod_q;
	logic [DIGIT_W-1:0]   digits_q [DEPTH];
	logic                 ok_q;

	// Output register.
	logic              res_valid_q;
	logic [CHAR_W-1:0] res_char_q;
	logic              res_last_q;

	// Combinational signals.
	logic [CHAR_W-1:0]      sym [SYM_COUNT];
	logic                   ok_d;
	logic [VALUE_W-1:0]     raw;
	logic [VALUE_W-1:0]     q_est;
	logic [10:0]            qr_low;
	logic [5:0]             rem0;
	logic                   over;
	logic [5:0]             digit_d;
	logic [VALUE_W-1:0]     q_fix;
	logic                   load_ok;
	logic [COUNT_W-1:0]     rd_cnt;
	logic [$clog2(DEPTH)-1:0] rd_idx;
	logic                   ld;
	logic [CHAR_W-1:0]      ld_char;
	logic                   ld_last;
	logic                   accept;

	assign cfg.ready     = 1'b1;
	assign operand.ready = (state_q == ST_IDLE);
	assign accept        = operand.valid && operand.ready;

	assign result.valid     = res_valid_q;
	assign result.character = res_char_q;
	assign result.last      = res_last_q;

	// The alphabet as sixteen bytes.
	always_comb begin
		for (int i = 0; i < SYM_COUNT; i++) begin
			sym[i] = (i < 8) ? symbols_low_q[(i % 8) * CHAR_W +: CHAR_W]
			                 : symbols_high_q[(i % 8) * CHAR_W +: CHAR_W];
		end
	end

	// Alphabet check: every symbol in use must be printable, not a sign and unique.
	// The result is registered; the user must not move the configuration while an operand
	// is in flight, unenforced, so the flag is current by the first correction cycle.
	always_comb begin
		ok_d = (radix_len_q >= RADIX_W'(2)) && (radix_len_q <= RADIX_W'(MAX_RADIX));
		for (int i = 0; i < SYM_COUNT; i++) begin
			if (RADIX_W'(i) < radix_len_q) begin
				if (sym[i] <= CHAR_SPACE || sym[i] >= CHAR_DEL ||
				    sym[i] == CHAR_PLUS || sym[i] == CHAR_MINUS) begin
					ok_d = 1'b0;
				end
				for (int j = i + 1; j < SYM_COUNT; j++) begin
					if (RADIX_W'(j) < radix_len_q && sym[j] == sym[i]) begin
						ok_d = 1'b0;
					end
				end
			end
		end
	end

	// Quotient correction. The estimate from the reciprocal is at most one short,
	// so the true remainder lies below twice the radix and six bits of the
	// subtraction are enough.
	assign raw     = VALUE_W'(operand.value);
	assign q_est   = prod_q[2*VALUE_W-1:VALUE_W];
	assign qr_low  = q_est[5:0] * radix_len_q;
	assign rem0    = mag_q[5:0] - qr_low[5:0];
	assign over    = (rem0 >= 6'(radix_len_q));
	assign digit_d = over ? (rem0 - 6'(radix_len_q)) : rem0;
	assign q_fix   = q_est + VALUE_W'(over);

	// Read-out walks the digit stack downwards.
	assign load_ok = !res_valid_q || result.ready;
	assign rd_cnt  = nd_q - COUNT_W'(1);
	assign rd_idx  = rd_cnt[$clog2(DEPTH)-1:0];

	// Next state and output register load.
	always_comb begin
		state_d = state_q;
		ld      = 1'b0;
		ld_char = sym[digits_q[rd_idx]];
		ld_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (operand.valid) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_FIX;
			end
			ST_FIX: begin
				if (!ok_q) begin
					state_d = ST_IDLE;
				end else if (q_fix != '0 && nd_q < COUNT_W'(DEPTH - 1)) begin
					state_d = ST_MUL;
				end else if (neg_q) begin
					state_d = ST_SIGN;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (load_ok) begin
					ld      = 1'b1;
					ld_char = CHAR_MINUS;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (load_ok) begin
					ld      = 1'b1;
					ld_last = (nd_q == COUNT_W'(1));
					if (nd_q == COUNT_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			nd_q           <= '0;
			res_valid_q    <= 1'b0;
			ok_q           <= 1'b0;
			symbols_low_q  <= '0;
			symbols_high_q <= '0;
			radix_len_q    <= '0;
		end else begin
			state_q <= state_d;
			ok_q    <= ok_d;
			if (accept) begin
				nd_q <= '0;
			end else if (state_q == ST_FIX && ok_q) begin
				nd_q <= nd_q + COUNT_W'(1);
			end else if (state_q == ST_EMIT && ld) begin
				nd_q <= rd_cnt;
			end
			if (ld) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				unique case (cfg_idx_t'(cfg.index))
					CFG_SYMBOLS_LOW:  symbols_low_q  <= cfg.data;
					CFG_SYMBOLS_HIGH: symbols_high_q <= cfg.data;
					CFG_RADIX_LEN:    radix_len_q    <= cfg.data[RADIX_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Datapath registers and the digit stack.
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= raw[VALUE_W-1];
			mag_q <= raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
		end else if (state_q == ST_FIX && ok_q) begin
			mag_q <= q_fix;
		end
		if (state_q == ST_MUL) begin
			prod_q <= mag_q * recip(radix_len_q);
		end
		if (state_q == ST_FIX && ok_q) begin
			digits_q[nd_q[$clog2(DEPTH)-1:0]] <= digit_d[DIGIT_W-1:0];
		end
		if (ld) begin
			res_char_q <= ld_char;
			res_last_q <= ld_last;
		end
	end

	// An accepted operand starts a fresh division with an empty digit stack.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_MUL && nd_q == '0))
		else $error("operand accept did not start the divider");

	// The corrected remainder is a proper digit of the radix.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIX && ok_q) |-> (digit_d < 6'(radix_len_q)))
		else $error("divider remainder not below radix");

	// Loading the final character frees the unit for the next operand.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ld && ld_last) |=> (state_q == ST_IDLE && res_valid_q && res_last_q))
		else $error("final character did not return the unit to idle");

	// The digit count never passes the stack depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIX) |-> (nd_q < COUNT_W'(DEPTH)))
		else $error("digit stack overflow");

endmodule

[tb/signed_int_to_radix_digits_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for signed_int_to_radix_digits_unit: directed table, then random phases.
// Depends on sird_pkg, the channel interfaces in sird_if.sv and the unit's top level.
module signed_int_to_radix_digits_unit_test;
	import sird_pkg::*;

	// One character beat as it should leave the result channel.
	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} char_beat_t;

	// A directed row names the alphabet in force and the operand. Where the characters can
	// be read off at a glance they are typed in; an empty text with typed set means that no
	// characters at all may come out.
	typedef struct {
		logic [CFG_DATA_W-1:0] sym_lo;
		logic [CFG_DATA_W-1:0] sym_hi;
		logic [RADIX_W-1:0]    radix;
		logic [VALUE_W-1:0]    value;
		bit                    typed;
		string                 text;
	} directed_row_t;

	localparam int unsigned DIRECTED_ROWS = 26;
	localparam int unsigned RANDOM_ITEMS  = 425;
	localparam int unsigned SETTLE_CYCLES = 120;
	localparam int unsigned TAIL_CYCLES   = 150;
	localparam int unsigned IDLE_PERCENT  = 29;
	localparam int unsigned MAX_REPORTS   = 10;

	// Digits '0' to '7' in the low word; the high words below complete the alphabets.
	localparam logic [CFG_DATA_W-1:0] DIGITS_LO = 64'h3736_3534_3332_3130;
	// '8' and '9', then bytes that would be illegal if they were in use.
	localparam logic [CFG_DATA_W-1:0] DEC_HI    = 64'hA5C3_0000_0000_3938;
	localparam logic [CFG_DATA_W-1:0] HEX_HI    = 64'h4645_4443_4241_3938;
	// '0' and '1', followed by illegal bytes that lie beyond the radix.
	localparam logic [CFG_DATA_W-1:0] BIN_LO    = 64'hFF00_2D2B_7F20_3130;
	localparam logic [CFG_DATA_W-1:0] BIN_HI    = 64'h0123_4567_89AB_CDEF;
	// The lowest and highest printable symbols, '!' and '~'.
	localparam logic [CFG_DATA_W-1:0] EDGE_LO   = 64'h0000_0000_0000_7E21;

	localparam logic [VALUE_W-1:0] MOST_NEG = 32'h8000_0000;
	localparam logic [VALUE_W-1:0] MOST_POS = 32'h7FFF_FFFF;

	logic clk = 1'b0;
	logic arst_n;

	sird_cfg_if cfg_ch ();
	sird_in_if  op_ch ();
	sird_out_if res_ch ();

	signed_int_to_radix_digits_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.operand (op_ch),
		.result  (res_ch)
	);

	always #4 clk = ~clk;

	// Mirror of the configuration registers as the unit should hold them.
	logic [CFG_DATA_W-1:0] sym_lo_q = '0;
	logic [CFG_DATA_W-1:0] sym_hi_q = '0;
	logic [RADIX_W-1:0]    radix_q  = '0;

	// Characters predicted but not yet seen, oldest first.
	char_beat_t expected_chars [$];
	char_beat_t oldest_char;
	int         fault_count = 0;
	int         char_index  = 0;

	// While calm is set neither side of the unit idles or stalls.
	bit calm = 1'b0;

	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		// Straight out of reset the radix is zero, so nothing may come out.
		'{64'h0, 64'h0, 5'd0, 32'd12345, 1'b1, ""},
		// Hexadecimal, the widest alphabet.
		'{DIGITS_LO, HEX_HI, 5'd16, 32'h0000_0000, 1'b1, "0"},
		'{DIGITS_LO, HEX_HI, 5'd16, 32'hFFFF_FFFF, 1'b1, "-1"},
		'{DIGITS_LO, HEX_HI, 5'd16, MOST_NEG, 1'b1, "-80000000"},
		'{DIGITS_LO, HEX_HI, 5'd16, MOST_POS, 1'b1, "7FFFFFFF"},
		'{DIGITS_LO, HEX_HI, 5'd16, 32'hDEAD_BEEF, 1'b0, ""},
		// Decimal, with illegal bytes above the radix that must be ignored.
		'{DIGITS_LO, DEC_HI, 5'd10, MOST_NEG, 1'b1, "-2147483648"},
		'{DIGITS_LO, DEC_HI, 5'd10, MOST_POS, 1'b1, "2147483647"},
		'{DIGITS_LO, DEC_HI, 5'd10, 32'hFFFF_FFF9, 1'b1, "-7"},
		'{DIGITS_LO, DEC_HI, 5'd10, 32'd1000000007, 1'b0, ""},
		// Binary: the most negative value gives the longest run of all.
		'{BIN_LO, BIN_HI, 5'd2, MOST_NEG, 1'b0, ""},
		'{BIN_LO, BIN_HI, 5'd2, MOST_POS, 1'b0, ""},
		'{BIN_LO, BIN_HI, 5'd2, 32'h0000_0000, 1'b1, "0"},
		'{BIN_LO, BIN_HI, 5'd2, 32'd5, 1'b1, "101"},
		// The lowest and highest legal symbols.
		'{EDGE_LO, 64'h0, 5'd2, 32'd2, 1'b1, "~!"},
		'{EDGE_LO, 64'h0, 5'd2, 32'hFFFF_FFFD, 1'b1, "-~~"},
		// Alphabets that must be rejected: too short, too long.
		'{DIGITS_LO, HEX_HI, 5'd1, 32'd7, 1'b1, ""},
		'{DIGITS_LO, HEX_HI, 5'd17, 32'd7, 1'b1, ""},
		'{DIGITS_LO, HEX_HI, 5'd31, 32'hFFFF_FFFD, 1'b1, ""},
		// Plus, minus, space and delete among the symbols in use.
		'{64'h3736_3534_3332_2B30, HEX_HI, 5'd16, 32'd9, 1'b1, ""},
		'{64'h3736_3534_3332_2D30, HEX_HI, 5'd16, 32'd9, 1'b1, ""},
		'{64'h3736_3534_3332_2030, HEX_HI, 5'd16, 32'd9, 1'b1, ""},
		'{64'h3736_3534_3332_7F30, HEX_HI, 5'd16, 32'd9, 1'b1, ""},
		// A byte of 255, which lies above delete, and a zero byte in the last slot.
		'{DIGITS_LO, 64'h4645_4443_4241_39FF, 5'd16, 32'd9, 1'b1, ""},
		'{DIGITS_LO, 64'h0045_4443_4241_3938, 5'd16, 32'd9, 1'b1, ""},
		// The last symbol repeats the first.
		'{DIGITS_LO, 64'h3045_4443_4241_3938, 5'd16, 32'd9, 1'b1, ""}
	};

	function automatic logic [CHAR_W-1:0] symbol_of(input int unsigned idx);
		if (idx < 8)
			return sym_lo_q[idx*8 +: 8];
		return sym_hi_q[(idx-8)*8 +: 8];
	endfunction

	// The alphabet is checked on every operand; any fault silences the whole operand.
	function automatic bit alphabet_usable();
		logic [CHAR_W-1:0] c;
		if (radix_q < 2 || radix_q > RADIX_W'(MAX_RADIX))
			return 1'b0;
		for (int i = 0; i < int'(radix_q); i++) begin
			c = symbol_of(i);
			if (c == CHAR_PLUS || c == CHAR_MINUS || c <= CHAR_SPACE || c >= CHAR_DEL)
				return 1'b0;
			for (int j = i + 1; j < int'(radix_q); j++)
				if (symbol_of(j) == c)
					return 1'b0;
		end
		return 1'b1;
	endfunction

	// Works out the characters of one operand under the mirrored alphabet. The magnitude is
	// taken as an unsigned number, so the most negative value needs no special handling.
	function automatic void predict_characters(input logic [VALUE_W-1:0] value);
		logic [VALUE_W-1:0] mag;
		logic [VALUE_W-1:0] radix;
		logic [DIGIT_W-1:0] digit_stack [DEPTH];
		int                 count;
		if (!alphabet_usable())
			return;
		radix = VALUE_W'(radix_q);
		mag   = value[VALUE_W-1] ? (32'd0 - value) : value;
		count = 0;
		do begin
			digit_stack[count] = DIGIT_W'(mag % radix);
			mag = mag / radix;
			count++;
		end while (mag != 0);
		if (value[VALUE_W-1])
			expected_chars.push_back('{CHAR_MINUS, 1'b0});
		for (int k = count - 1; k >= 0; k--)
			expected_chars.push_back('{symbol_of(int'(digit_stack[k])), k == 0});
	endfunction

	function automatic void expect_text(input string text);
		for (int i = 0; i < text.len(); i++)
			expected_chars.push_back('{CHAR_W'(text[i]), i == text.len() - 1});
	endfunction

	function automatic void record_fault(input string what);
		fault_count++;
		if (fault_count <= MAX_REPORTS)
			$display("%0t ns: %s", $realtime, what);
	endfunction

	// Operand values: a quarter full-range, a quarter small, a quarter from the corners
	// and near powers of the radix, a quarter of random magnitude width and sign.
	function automatic logic [VALUE_W-1:0] draw_value();
		logic [VALUE_W-1:0] r;
		logic [VALUE_W-1:0] v;
		r = VALUE_W'(radix_q);
		case ($urandom_range(3))
			0: v = $urandom;
			1: v = VALUE_W'($urandom_range(200)) - 32'd100;
			2: begin
				case ($urandom_range(7))
					0: v = MOST_NEG;
					1: v = MOST_POS;
					2: v = '0;
					3: v = '1;
					4: v = 32'd1;
					5: v = r - 32'd1;
					6: v = r;
					default: v = 32'd0 - r * r;
				endcase
			end
			default: begin
				v = $urandom >> $urandom_range(31);
				if ($urandom_range(1) == 1)
					v = 32'd0 - v;
			end
		endcase
		return v;
	endfunction

	// Draws a random alphabet. Symbols in use are distinct printable bytes; those beyond the
	// radix are random bytes of any value. A wanted fault is then planted on top.
	function automatic void draw_alphabet(input bit want_usable, input int forced_len,
			output logic [CFG_DATA_W-1:0] lo, output logic [CFG_DATA_W-1:0] hi,
			output logic [RADIX_W-1:0] len);
		logic [CHAR_W-1:0] sym [SYM_COUNT];
		logic [CHAR_W-1:0] c;
		int                n;
		int                i;
		bit                clash;
		for (i = 0; i < int'(SYM_COUNT); i++)
			sym[i] = CHAR_W'($urandom);
		if (forced_len != 0)
			n = forced_len;
		else
			case ($urandom_range(3))
				0: n = 2;
				1: n = MAX_RADIX;
				default: n = $urandom_range(3, MAX_RADIX - 1);
			endcase
		for (i = 0; i < n; i++) begin
			do begin
				c = CHAR_W'($urandom_range(33, 126));
				clash = (c == CHAR_PLUS || c == CHAR_MINUS);
				for (int j = 0; j < i; j++)
					if (sym[j] == c)
						clash = 1'b1;
			end while (clash);
			sym[i] = c;
		end
		if (!want_usable) begin
			case ($urandom_range(3))
				0: n = $urandom_range(1);
				1: n = $urandom_range(17, 31);
				2: begin
					case ($urandom_range(3))
						0: c = ($urandom_range(1) == 1) ? CHAR_PLUS : CHAR_MINUS;
						1: c = CHAR_W'($urandom_range(32));
						2: c = CHAR_DEL;
						default: c = CHAR_W'($urandom_range(128, 255));
					endcase
					sym[$urandom_range(n - 1)] = c;
				end
				default: begin
					i = $urandom_range(1, n - 1);
					sym[i] = sym[$urandom_range(i - 1)];
				end
			endcase
		end
		for (i = 0; i < 8; i++) begin
			lo[i*8 +: 8] = sym[i];
			hi[i*8 +: 8] = sym[i+8];
		end
		len = RADIX_W'(n);
	endfunction

	// The receiver stalls at random, decided afresh at every falling edge.
	always @(negedge clk)
		res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);

	// Every character beat is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_chars.size() == 0) begin
				record_fault($sformatf("character beat %0d: %02h last %0b with nothing expected",
					char_index, res_ch.character, res_ch.last));
			end else begin
				oldest_char = expected_chars.pop_front();
				if (res_ch.character !== oldest_char.character ||
						res_ch.last !== oldest_char.last)
					record_fault($sformatf(
						"character beat %0d: expected %02h last %0b, got %02h last %0b",
						char_index, oldest_char.character, oldest_char.last,
						res_ch.character, res_ch.last));
			end
			char_index++;
		end
	end

	// Offers one operand beat. The sender idles at random first; the task returns at the
	// rising edge that accepts the beat, so valid stays high into the next call.
	task automatic push_operand(input logic [VALUE_W-1:0] value);
		@(negedge clk);
		while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
			op_ch.valid <= 1'b0;
			@(negedge clk);
		end
		op_ch.valid <= 1'b1;
		op_ch.value <= value;
		forever begin
			@(posedge clk);
			if (op_ch.ready)
				break;
		end
	endtask

	task automatic release_operand();
		@(negedge clk);
		op_ch.valid <= 1'b0;
	endtask

	task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		forever begin
			@(posedge clk);
			if (cfg_ch.ready)
				break;
		end
		case (idx)
			CFG_SYMBOLS_LOW:  sym_lo_q = data;
			CFG_SYMBOLS_HIGH: sym_hi_q = data;
			CFG_RADIX_LEN:    radix_q  = data[RADIX_W-1:0];
			default: ;
		endcase
	endtask

	// Registers only change while the unit is idle: every predicted character must have
	// left, and an operand under a rejected alphabet may still be in the divider, so a
	// settling pause longer than the slowest binary conversion follows.
	task automatic load_alphabet(input logic [CFG_DATA_W-1:0] lo,
			input logic [CFG_DATA_W-1:0] hi, input logic [RADIX_W-1:0] len);
		release_operand();
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_register(CFG_SYMBOLS_LOW, lo);
		write_register(CFG_SYMBOLS_HIGH, hi);
		write_register(CFG_RADIX_LEN, CFG_DATA_W'(len));
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] lo;
		logic [CFG_DATA_W-1:0] hi;
		logic [RADIX_W-1:0]    len;
		logic [VALUE_W-1:0]    value;
		int                    phase;
		int                    counted;
		int                    phase_items;
		bit                    live;

		arst_n       = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_SYMBOLS_LOW;
		cfg_ch.data  = '0;
		op_ch.valid  = 1'b0;
		op_ch.value  = '0;
		res_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table. The first row runs under the reset configuration.
		for (int r = 0; r < int'(DIRECTED_ROWS); r++) begin
			if (directed_rows[r].sym_lo !== sym_lo_q || directed_rows[r].sym_hi !== sym_hi_q ||
					directed_rows[r].radix !== radix_q)
				load_alphabet(directed_rows[r].sym_lo, directed_rows[r].sym_hi,
					directed_rows[r].radix);
			push_operand(directed_rows[r].value);
			if (directed_rows[r].typed)
				expect_text(directed_rows[r].text);
			else
				predict_characters(directed_rows[r].value);
		end

		// Random phases. Most alphabets are usable; a rejected one only gets a handful of
		// beats, and those beats do not count towards the total. The first phases pin the
		// radix to its extremes and the fourth runs without any idling on either side.
		phase   = 0;
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			draw_alphabet(phase < 4 || $urandom_range(3) != 0,
				(phase == 0) ? 2 : (phase == 1) ? MAX_RADIX : 0, lo, hi, len);
			load_alphabet(lo, hi, len);
			live = alphabet_usable();
			calm = (phase == 3);
			if (!live)
				phase_items = $urandom_range(3, 6);
			else if (calm)
				phase_items = 60;
			else
				phase_items = $urandom_range(20, 40);
			repeat (phase_items) begin
				value = draw_value();
				push_operand(value);
				predict_characters(value);
				if (live)
					counted++;
				// Now and then the sender holds off until the unit has drained.
				if (!calm && $urandom_range(24) == 0) begin
					release_operand();
					while (expected_chars.size() != 0)
						@(posedge clk);
				end
			end
			calm = 1'b0;
			phase++;
		end

		release_operand();
		while (expected_chars.size() != 0)
			@(posedge clk);
		// A quiet tail catches any stray beats after the last expected one.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_chars.size() != 0)
			record_fault($sformatf("%0d character beats never arrived", expected_chars.size()));
		if (fault_count == 0)
			$display("signed_int_to_radix_digits_unit verification clean");
		else
			$display("signed_int_to_radix_digits_unit verification failed");
		$finish;
	end

	// Watchdog, several times the slowest correct run.
	initial begin
		#6_000_000;
		$display("signed_int_to_radix_digits_unit verification failed");
		$finish;
	end

endmodule
